>>> rtl/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_value;
    logic [7:0]         item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       insert;
    logic       remove;
    logic       load_result;
    logic [1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level of the bounded sorted priority queue
`timescale 1ns / 1ps

// Bounded priority queue of CAPACITY entries kept in descending priority order in a
// row of register cells. Each beat is an insert or a remove and yields exactly one
// result beat the cycle after it is taken. An insert compares its priority against
// every cell at once and shifts the lower-priority tail down by one, so equal
// priorities leave first in, first out; a remove pops the head and shifts all cells
// up. One item completes per cycle unless stalled: the single output register is the
// only thing that holds the block, and a new beat is taken in the same cycle the
// previous result is taken. Remove on an empty queue reports status 1; an insert
// on a full queue is dropped with status 2. Occupancy shows the count modulo 32.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_data_i.kind),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/spq_ctrl.sv
// spq_ctrl: handshake control and operation decode for the sorted priority queue
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  spq_pkg::dp_status_t status_i,
  output spq_pkg::cmd_t      cmd_o
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  // the output register frees up in the same cycle its beat is taken
  assign in_stall_o = (state_q == S_HOLD) && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load_result = accept;
    cmd_o.code        = ST_DONE;
    if (accept) begin
      if (in_kind_i == KIND_INSERT) begin
        if (status_i.full) begin
          cmd_o.code = ST_FULL;
        end else begin
          cmd_o.insert = 1'b1;
        end
      end else begin
        if (status_i.empty) begin
          cmd_o.code = ST_EMPTY;
        end else begin
          cmd_o.remove = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = (state_q == S_HOLD);

endmodule

>>> rtl/spq_datapath.sv
// spq_datapath: sorted entry cells, entry count and result register
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::in_t        in_data_i,
  input  spq_pkg::cmd_t       cmd_i,
  output spq_pkg::dp_status_t status_o,
  output spq_pkg::out_t       out_data_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] val_q  [CAPACITY];
  logic [7:0]         prio_q [CAPACITY];
  logic [CAPACITY-1:0] ge;
  out_t               res_q;

  // cells holding an entry of equal or higher priority stay put; this is a prefix
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CntW'(i) < count_q) && (prio_q[i] >= in_data_i.item_priority);
    end
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(CAPACITY));

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) count_d = count_q + CntW'(1);
    else if (cmd_i.remove) count_d = count_q - CntW'(1);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               prev_ge;
    logic signed [31:0] prev_val;
    logic [7:0]         prev_prio;
    logic signed [31:0] next_val;
    logic [7:0]         next_prio;

    if (g == 0) begin : g_head
      assign prev_ge   = 1'b1;
      assign prev_val  = in_data_i.item_value;
      assign prev_prio = in_data_i.item_priority;
    end else begin : g_body
      assign prev_ge   = ge[g-1];
      assign prev_val  = val_q[g-1];
      assign prev_prio = prio_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_val  = val_q[g];
      assign next_prio = prio_q[g];
    end else begin : g_inner
      assign next_val  = val_q[g+1];
      assign next_prio = prio_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !ge[g]) begin
        if (prev_ge) begin
          val_q[g]  <= in_data_i.item_value;
          prio_q[g] <= in_data_i.item_priority;
        end else begin
          val_q[g]  <= prev_val;
          prio_q[g] <= prev_prio;
        end
      end else if (cmd_i.remove) begin
        val_q[g]  <= next_val;
        prio_q[g] <= next_prio;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_q.removed_value <= cmd_i.remove ? val_q[0] : 32'sd0;
      res_q.status        <= cmd_i.code;
      res_q.occupancy     <= 5'(count_d);
    end
  end

  assign out_data_o = res_q;

endmodule

>>> rtl/spq_checker.sv
// spq_checker: port-level assertions for the sorted priority queue
`timescale 1ns / 1ps

module spq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input spq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // every accepted beat shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> out_valid_o)
    else $error("no result after accepted beat");

  // no beat is taken while an unaccepted result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !in_acc)
    else $error("input taken while output stalled");

  // a stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a remove never reports a full drop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.kind == KIND_REMOVE) |=> out_data_o.status != ST_FULL)
    else $error("full status on remove");

  // only a successful pop carries a nonzero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.removed_value != 32'sd0) |-> out_data_o.status == ST_DONE)
    else $error("value returned with error status");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
